[hw/rtl/qdc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qdc_pkg;
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] VERDICT_HEAP  = 3'd0;
    localparam logic [2:0] VERDICT_FIFO  = 3'd1;
    localparam logic [2:0] VERDICT_STACK = 3'd2;
    localparam logic [2:0] VERDICT_MANY  = 3'd3;
    localparam logic [2:0] VERDICT_NONE  = 3'd4;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] value;
    } in_word_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       heap_ok;
        logic       stack_ok;
        logic       fifo_ok;
        logic       overflow;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic push;
    } heap_req_t;

    typedef struct packed {
        logic busy;
        logic head_match;
        logic empty;
        logic full;
    } heap_stat_t;
endpackage
`default_nettype wire

[hw/rtl/qdc_heap.sv]
`timescale 1ns / 1ps
`default_nettype none
module qdc_heap #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          clear,
    input  wire qdc_pkg::heap_req_t      req,
    input  wire logic signed [VALUE_BITS-1:0] value,
    output qdc_pkg::heap_stat_t          stat
);
    import qdc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UP_RD = 4'd1;
    localparam logic [3:0] S_UP_CK = 4'd2;
    localparam logic [3:0] S_DN_L  = 4'd3;
    localparam logic [3:0] S_DN_LW = 4'd4;
    localparam logic [3:0] S_DN_C1 = 4'd5;
    localparam logic [3:0] S_DN_C2 = 4'd6;
    localparam logic [3:0] S_DN_CK = 4'd7;
    localparam logic [3:0] S_DN_RD = 4'd8;

    logic signed [VALUE_BITS-1:0] mem [DEPTH];
    logic signed [VALUE_BITS-1:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic signed [VALUE_BITS-1:0] wr_data;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic signed [VALUE_BITS-1:0] top_reg, top_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic signed [VALUE_BITS-1:0] c1_reg, c1_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW:0]   child;
    logic [CW-1:0] parent;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    assign parent = (idx_reg - CW'(1)) >> 1;
    assign child  = {idx_reg, 1'b1};

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        top_next   = top_reg;
        val_next   = val_reg;
        c1_next    = c1_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = val_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start && req.push) begin
                    val_next   = value;
                    idx_next   = count_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_UP_RD;
                end else if (req.start) begin
                    count_next = count_reg - CW'(1);
                    idx_next   = '0;
                    if (count_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = S_DN_L;
                    end
                end
            end
            S_UP_RD: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    top_next   = val_reg;
                    state_next = S_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(parent);
                    state_next = S_UP_CK;
                end
            end
            S_UP_CK: begin
                wr_en = 1'b1;
                if (rd_data >= val_reg) begin
                    wr_addr    = AW'(idx_reg);
                    state_next = S_IDLE;
                end else begin
                    wr_addr    = AW'(idx_reg);
                    wr_data    = rd_data;
                    idx_next   = parent;
                    state_next = S_UP_RD;
                end
            end
            S_DN_L: begin
                val_next   = rd_data;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                if (child >= {1'b0, count_reg}) begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(idx_reg);
                    if (idx_reg == '0) begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(child);
                    state_next = S_DN_C1;
                end
            end
            S_DN_C1: begin
                c1_next = rd_data;
                if (child + 1'b1 < {1'b0, count_reg}) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(child + 1'b1);
                    state_next = S_DN_C2;
                end else begin
                    state_next = S_DN_CK;
                end
            end
            S_DN_C2: begin
                if (rd_data > c1_reg) begin
                    c1_next  = rd_data;
                    idx_next = CW'(child + 1'b1);
                end else begin
                    idx_next = CW'(child);
                end
                state_next = S_DN_LW;
            end
            S_DN_CK: begin
                idx_next   = CW'(child);
                state_next = S_DN_LW;
            end
            default: begin
                // idx_reg already holds the chosen child; c1_reg its value.
                // The parent index is recomputed from it.
                wr_addr = AW'((idx_reg - CW'(1)) >> 1);
                if (c1_reg <= val_reg) begin
                    wr_en    = 1'b1;
                    idx_next = (idx_reg - CW'(1)) >> 1;
                    if (((idx_reg - CW'(1)) >> 1) == '0) begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = c1_reg;
                    if (((idx_reg - CW'(1)) >> 1) == '0) begin
                        top_next = c1_reg;
                    end
                    state_next = S_DN_RD;
                end
            end
        endcase
        if (clear) begin
            count_next = '0;
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        top_reg <= top_next;
        val_reg <= val_next;
        c1_reg  <= c1_next;
        idx_reg <= idx_next;
    end

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == CW'(DEPTH));
    assign stat.head_match = (top_reg == value);
endmodule
`default_nettype wire

[hw/rtl/queue_discipline_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Checks a trace of push, pop and clear words against stack, queue and
// largest-first order at once.
// The input channel (s_) takes a command and a 16-bit signed value.
// The result channel (m_) returns one word per input: a verdict, the three
// order flags and a sticky overflow bit.
// Stack and queue live in memories whose heads are read at the accepting
// edge and checked in the next cycle.
// A clear, an unused command or a pop that leaves the heap alone goes
// through P_READ and P_HEAP and loads the result register once it is free.
// The heap sits in its own memory: a push sifts up through S_UP_RD and
// S_UP_CK at each level, and a pop sifts down through S_DN_RD, S_DN_C1,
// S_DN_C2 or S_DN_CK, and S_DN_LW at each level.
// After the result register is loaded the checker passes through P_DONE to
// P_IDLE, where it takes the next word.
// Reset empties all structures and sets all flags; no clearing pass is made.
// When the receiver stalls, the result word holds, one more word is taken
// and worked on, and then the input stalls until the result drains.
module queue_discipline_checker #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire qdc_pkg::in_word_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output qdc_pkg::out_word_t    m_data
);
    import qdc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_READ = 2'd1;
    localparam logic [1:0] P_HEAP = 2'd2;
    localparam logic [1:0] P_DONE = 2'd3;

    logic signed [VALUE_BITS-1:0] lifo_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] ring_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] lifo_rd, ring_rd;

    logic [1:0]    phase_reg;
    in_word_t      word_reg;
    logic signed [VALUE_BITS-1:0] val;
    logic [CW-1:0] lifo_cnt_reg, ring_cnt_reg;
    logic [AW-1:0] head_reg, tail_reg;
    logic [2:0]    flags_reg;
    logic          ovf_reg;
    logic          take;
    logic          emit;
    heap_req_t     hreq;
    heap_stat_t    hstat;
    logic          heap_clear;
    logic          lifo_full, ring_full, heap_full;

    assign s_ready = (phase_reg == P_IDLE);
    assign take    = s_valid && s_ready;
    assign val     = VALUE_BITS'(signed'(word_reg.value));
    assign emit    = (phase_reg == P_HEAP) && !hstat.busy && (!m_valid || m_ready);

    assign lifo_full = (lifo_cnt_reg == CW'(DEPTH));
    assign ring_full = (ring_cnt_reg == CW'(DEPTH));
    assign heap_full = hstat.full;

    always_ff @(posedge aclk) begin
        if (phase_reg == P_READ && word_reg.command == CMD_PUSH && !lifo_full) begin
            lifo_mem[AW'(lifo_cnt_reg)] <= val;
        end
        if (phase_reg == P_READ && word_reg.command == CMD_PUSH && !ring_full) begin
            ring_mem[tail_reg] <= val;
        end
        if (take) begin
            lifo_rd <= lifo_mem[AW'(lifo_cnt_reg - CW'(1))];
            ring_rd <= ring_mem[head_reg];
        end
    end

    assign heap_clear = (phase_reg == P_READ) && (word_reg.command == CMD_CLEAR);
    assign hreq.start = (phase_reg == P_READ) &&
                        ((word_reg.command == CMD_PUSH && !heap_full) ||
                         (word_reg.command == CMD_POP && !hstat.empty &&
                          hstat.head_match && flags_reg[0]) ||
                         (word_reg.command == CMD_POP && !hstat.empty &&
                          hstat.head_match && !flags_reg[0]));
    assign hreq.push  = (word_reg.command == CMD_PUSH);

    qdc_heap #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (heap_clear),
        .req     (hreq),
        .value   (val),
        .stat    (hstat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= P_IDLE;
            lifo_cnt_reg <= '0;
            ring_cnt_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            flags_reg    <= 3'b111;
            ovf_reg      <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (emit) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            unique case (phase_reg)
                P_IDLE: begin
                    if (take) begin
                        word_reg  <= s_data;
                        phase_reg <= P_READ;
                    end
                end
                P_READ: begin
                    phase_reg <= P_HEAP;
                    case (word_reg.command)
                        CMD_PUSH: begin
                            if (heap_full || lifo_full || ring_full) begin
                                ovf_reg <= 1'b1;
                            end
                            if (!lifo_full) begin
                                lifo_cnt_reg <= lifo_cnt_reg + CW'(1);
                            end
                            if (!ring_full) begin
                                ring_cnt_reg <= ring_cnt_reg + CW'(1);
                                tail_reg <= (tail_reg == AW'(DEPTH - 1)) ? '0
                                                                       : tail_reg + AW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (hstat.empty || !hstat.head_match) begin
                                flags_reg[0] <= 1'b0;
                            end
                            if (lifo_cnt_reg != '0 && lifo_rd == val) begin
                                lifo_cnt_reg <= lifo_cnt_reg - CW'(1);
                            end else begin
                                flags_reg[1] <= 1'b0;
                            end
                            if (ring_cnt_reg != '0 && ring_rd == val) begin
                                ring_cnt_reg <= ring_cnt_reg - CW'(1);
                                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0
                                                                       : head_reg + AW'(1);
                            end else begin
                                flags_reg[2] <= 1'b0;
                            end
                        end
                        CMD_CLEAR: begin
                            lifo_cnt_reg <= '0;
                            ring_cnt_reg <= '0;
                            head_reg     <= '0;
                            tail_reg     <= '0;
                            flags_reg    <= 3'b111;
                            ovf_reg      <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                P_HEAP: begin
                    if (emit) begin
                        phase_reg <= P_DONE;
                    end
                end
                default: begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data.heap_ok  <= flags_reg[0];
            m_data.stack_ok <= flags_reg[1];
            m_data.fifo_ok  <= flags_reg[2];
            m_data.overflow <= ovf_reg;
            unique case (flags_reg)
                3'b001:  m_data.verdict <= VERDICT_HEAP;
                3'b100:  m_data.verdict <= VERDICT_FIFO;
                3'b010:  m_data.verdict <= VERDICT_STACK;
                3'b000:  m_data.verdict <= VERDICT_NONE;
                default: m_data.verdict <= VERDICT_MANY;
            endcase
        end
    end
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import qdc_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;

    queue_discipline_checker i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predictor state: three views of the same trace.
    logic signed [15:0] heap_mem [DEPTH];
    logic signed [15:0] lifo_mem [DEPTH];
    logic signed [15:0] ring_mem [DEPTH];
    int heap_n, lifo_n, ring_n, ring_rd, ring_wr;
    logic ok_heap, ok_stack, ok_fifo, ovf_seen;

    out_word_t verdict_q[$];
    int fail_count = 0;
    bit quiet_tail = 1'b0;
    bit rx_hold = 1'b0;

    task automatic trace_clear();
        heap_n = 0; lifo_n = 0; ring_n = 0; ring_rd = 0; ring_wr = 0;
        ok_heap = 1'b1; ok_stack = 1'b1; ok_fifo = 1'b1; ovf_seen = 1'b0;
    endtask

    task automatic heap_insert(input logic signed [15:0] v);
        int i, p;
        i = heap_n;
        heap_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_mem[p] >= v) break;
            heap_mem[i] = heap_mem[p];
            i = p;
        end
        heap_mem[i] = v;
    endtask

    task automatic heap_remove();
        logic signed [15:0] last;
        int i, c;
        i = 0;
        heap_n--;
        if (heap_n != 0) begin
            last = heap_mem[heap_n];
            forever begin
                c = 2 * i + 1;
                if (c >= heap_n) break;
                if (c + 1 < heap_n && heap_mem[c + 1] > heap_mem[c]) c++;
                if (heap_mem[c] <= last) break;
                heap_mem[i] = heap_mem[c];
                i = c;
            end
            heap_mem[i] = last;
        end
    endtask

    function automatic out_word_t verdict_of();
        out_word_t r;
        r.heap_ok = ok_heap;
        r.stack_ok = ok_stack;
        r.fifo_ok = ok_fifo;
        r.overflow = ovf_seen;
        case ({ok_heap, ok_stack, ok_fifo})
            3'b100: r.verdict = VERDICT_HEAP;
            3'b001: r.verdict = VERDICT_FIFO;
            3'b010: r.verdict = VERDICT_STACK;
            3'b000: r.verdict = VERDICT_NONE;
            default: r.verdict = VERDICT_MANY;
        endcase
        return r;
    endfunction

    task automatic predict_order(input in_word_t w);
        if (w.command == CMD_PUSH) begin
            if (heap_n < DEPTH) heap_insert(w.value); else ovf_seen = 1'b1;
            if (lifo_n < DEPTH) begin
                lifo_mem[lifo_n] = w.value;
                lifo_n++;
            end else ovf_seen = 1'b1;
            if (ring_n < DEPTH) begin
                ring_mem[ring_wr] = w.value;
                ring_wr = (ring_wr + 1) % DEPTH;
                ring_n++;
            end else ovf_seen = 1'b1;
        end else if (w.command == CMD_POP) begin
            if (heap_n > 0 && heap_mem[0] == w.value) heap_remove();
            else ok_heap = 1'b0;
            if (lifo_n > 0 && lifo_mem[lifo_n - 1] == w.value) lifo_n--;
            else ok_stack = 1'b0;
            if (ring_n > 0 && ring_mem[ring_rd] == w.value) begin
                ring_rd = (ring_rd + 1) % DEPTH;
                ring_n--;
            end else ok_fifo = 1'b0;
        end else if (w.command == CMD_CLEAR) begin
            trace_clear();
        end
        verdict_q.push_back(verdict_of());
    endtask

    // Valid stays high from one word to the next unless an idle burst comes.
    task automatic send_word(input in_word_t w, input bit gaps);
        if (gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_order(w);
    endtask

    // Directed rows: command, value, expected result where it is obvious.
    typedef struct {
        logic [1:0] cmd;
        logic signed [15:0] val;
        bit known;
        out_word_t res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic out_word_t ow(logic [2:0] v, logic h, logic s, logic f, logic o);
        out_word_t r;
        r.verdict = v; r.heap_ok = h; r.stack_ok = s; r.fifo_ok = f; r.overflow = o;
        return r;
    endfunction

    task automatic add_row(logic [1:0] c, logic signed [15:0] v, bit k, out_word_t r);
        dir_row_t d;
        d.cmd = c; d.val = v; d.known = k; d.res = r;
        dir_rows.push_back(d);
    endtask

    // A mostly well-formed trace for one discipline, with random content.
    task automatic random_trace(input int kind, input int len);
        logic signed [15:0] held[$];
        logic signed [15:0] v;
        in_word_t w;
        int k, mx;
        w.command = CMD_CLEAR; w.value = 16'($urandom);
        send_word(w, 1);
        for (int n = 0; n < len; n++) begin
            if (held.size() == 0 || $urandom_range(0, 1) == 0) begin
                v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
                held.push_back(v);
                w.command = CMD_PUSH; w.value = v;
            end else begin
                if (kind == 0) begin
                    mx = 0;
                    for (k = 1; k < held.size(); k++) if (held[k] > held[mx]) mx = k;
                end else if (kind == 1) mx = 0;
                else mx = held.size() - 1;
                w.command = CMD_POP; w.value = held[mx];
                if ($urandom_range(0, 19) == 0) w.value = 16'($urandom);
                held.delete(mx);
            end
            if ($urandom_range(0, 39) == 0) w.command = CMD_UNUSED;
            send_word(w, 1);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver: random stall bursts, or a long hold when asked.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                rx_hold = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                out_word_t e;
                e = verdict_q.pop_front();
                if (m_data.verdict !== e.verdict) begin
                    $error("verdict exp %0d got %0d", e.verdict, m_data.verdict);
                    fail_count++;
                end
                if (m_data.heap_ok !== e.heap_ok) begin
                    $error("heap_ok exp %0d got %0d", e.heap_ok, m_data.heap_ok);
                    fail_count++;
                end
                if (m_data.stack_ok !== e.stack_ok) begin
                    $error("stack_ok exp %0d got %0d", e.stack_ok, m_data.stack_ok);
                    fail_count++;
                end
                if (m_data.fifo_ok !== e.fifo_ok) begin
                    $error("fifo_ok exp %0d got %0d", e.fifo_ok, m_data.fifo_ok);
                    fail_count++;
                end
                if (m_data.overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, m_data.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        in_word_t w;
        out_word_t e;
        int wait_cnt;
        trace_clear();
        add_row(CMD_POP, 16'sd5, 1, ow(VERDICT_NONE, 0, 0, 0, 0));
        add_row(CMD_CLEAR, 16'sd0, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, -16'sd32768, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, 16'sd32767, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, 16'sd0, 0, '0);
        add_row(CMD_PUSH, -16'sd1, 0, '0);
        add_row(CMD_POP, 16'sd32767, 1, ow(VERDICT_HEAP, 1, 0, 0, 0));
        add_row(CMD_POP, 16'sd0, 0, '0);
        add_row(CMD_UNUSED, 16'sd99, 0, '0);
        add_row(CMD_CLEAR, -16'sd1, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, 16'sd7, 0, '0);
        add_row(CMD_PUSH, 16'sd3, 0, '0);
        add_row(CMD_POP, 16'sd7, 0, '0);
        add_row(CMD_POP, 16'sd3, 0, '0);
        add_row(CMD_CLEAR, 16'sd0, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, 16'sd1, 0, '0);
        add_row(CMD_PUSH, 16'sd9, 0, '0);
        add_row(CMD_POP, 16'sd9, 1, ow(VERDICT_MANY, 1, 1, 0, 0));
        add_row(CMD_POP, 16'sd1, 0, '0);
        add_row(CMD_CLEAR, 16'sd0, 1, ow(VERDICT_MANY, 1, 1, 1, 0));
        add_row(CMD_PUSH, 16'sd2, 0, '0);
        add_row(CMD_PUSH, 16'sd8, 0, '0);
        add_row(CMD_POP, 16'sd2, 1, ow(VERDICT_FIFO, 0, 0, 1, 0));
        add_row(CMD_CLEAR, 16'sd0, 1, ow(VERDICT_MANY, 1, 1, 1, 0));

        @(posedge aclk iff aresetn);
        foreach (dir_rows[i]) begin
            w.command = dir_rows[i].cmd;
            w.value = dir_rows[i].val;
            send_word(w, 1);
            if (dir_rows[i].known) begin
                e = verdict_q[verdict_q.size() - 1];
                if (e !== dir_rows[i].res) begin
                    $error("directed row %0d: expected %h, predictor %h",
                           i, dir_rows[i].res, e);
                    fail_count++;
                end
            end
        end

        // Keep offering pushes, then pops, while the receiver holds off.
        rx_hold = 1'b1;
        for (int n = 0; n < 60; n++) begin
            w.command = CMD_PUSH; w.value = 16'($urandom);
            send_word(w, 0);
        end
        for (int n = 0; n < 5; n++) begin
            w.command = CMD_POP; w.value = 16'($urandom);
            send_word(w, 0);
        end

        // Sender pause until everything has drained.
        s_valid <= 1'b0;
        wait (verdict_q.size() == 0);

        for (int t = 0; t < 60; t++) begin
            if (t == 50) quiet_tail = 1'b1;
            random_trace($urandom_range(0, 3), $urandom_range(4, 20));
        end
        s_valid <= 1'b0;

        wait_cnt = 0;
        while (verdict_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

[files.f]
hw/rtl/qdc_pkg.sv
hw/rtl/qdc_heap.sv
hw/rtl/queue_discipline_checker.sv
sim/tb_top.sv
